// ===== rtl/core/tadc_pkg.sv =====
// Shared types and constants for the thermistor ADC to temperature block.
// Used by every module and interface under rtl/core; no dependencies.
package tadc_pkg;

   localparam int ADC_W     = 16;
   localparam int SUM_W     = 23;
   localparam int CNT_W     = 7;
   localparam int VO_W      = 23;
   localparam int OHMS_W    = 24;
   localparam int TEMP_W    = 16;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   localparam logic [CNT_W-1:0] MAX_SAMPLES = 7'd64;

   localparam logic [22:0] FULL_SCALE_UV = 23'd4096000;
   localparam logic [14:0] CODE_FULL     = 15'd32767;
   localparam logic [31:0] LN2_Q32       = 32'd2977044472;

   // divider and log unit sizes
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 45;
   localparam int DIV_CNT_W = 6;
   localparam int LOG_IN_W  = 23;
   localparam int LOG_W     = 29;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BALANCE_OHMS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_KELVIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL_CK     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY_UV      = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HIGH = 2'd2;

   typedef struct packed {
      logic [23:0] balance_ohms;
      logic [15:0] beta_kelvin;
      logic [15:0] nominal_centikelvin;
      logic [21:0] supply_microvolts;
   } cfg_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        cnt;
   } avg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                start;
      logic [LOG_IN_W-1:0] x;
   } log_req_type;

   typedef struct packed {
      logic             busy;
      logic [LOG_W-1:0] value;
   } log_rsp_type;

endpackage

// ===== rtl/core/tadc_if.sv =====
// Valid/ready channel interfaces for ADC codes in and temperature results out.
// Depends on tadc_pkg.
interface tadc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [tadc_pkg::ADC_W-1:0]   adc_code;

   modport source (output valid, output adc_code, input ready);
   modport sink   (input valid, input adc_code, output ready);
endinterface

interface tadc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tadc_pkg::TEMP_W-1:0]   celsius_centi;
   logic signed [tadc_pkg::TEMP_W-1:0]   fahrenheit_centi;
   logic signed [tadc_pkg::VO_W-1:0]     divider_microvolts;
   logic [tadc_pkg::OHMS_W-1:0]          thermistor_ohms;
   logic [tadc_pkg::STATUS_W-1:0]        status;

   modport source (output valid, output celsius_centi, output fahrenheit_centi,
                   output divider_microvolts, output thermistor_ohms, output status,
                   input ready);
   modport sink   (input valid, input celsius_centi, input fahrenheit_centi,
                   input divider_microvolts, input thermistor_ohms, input status,
                   output ready);
endinterface

// ===== rtl/core/tadc_front.sv =====
// Front end: accepts ADC codes, accumulates them and queues finished averages.
// Depends on tadc_pkg and tadc_if.
module tadc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [tadc_pkg::CNT_W-1:0]   sample_count,
   tadc_req_if.sink                     req_chan,
   input  logic                         fifo_full,
   output logic                         push,
   output tadc_pkg::avg_type            push_data
);
   import tadc_pkg::*;

   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_new;
   logic [CNT_W-1:0]        taken_ff, taken_in, taken_new;
   logic [CNT_W-1:0]        need;
   logic                    accept;

   always_comb begin
      priority if (sample_count == '0) begin
         need = CNT_W'(1);
      end else if (sample_count > MAX_SAMPLES) begin
         need = MAX_SAMPLES;
      end else begin
         need = sample_count;
      end
   end

   assign req_chan.ready = !fifo_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign sum_new        = sum_ff + {{(SUM_W-ADC_W){req_chan.adc_code[ADC_W-1]}},
                                     req_chan.adc_code};
   assign taken_new      = taken_ff + CNT_W'(1);

   // a lowered count mid-average closes the average on the next code
   assign push           = accept && (taken_new >= need);
   assign push_data.sum  = sum_new;
   assign push_data.cnt  = taken_new;

   always_comb begin
      sum_in   = sum_ff;
      taken_in = taken_ff;
      if (accept) begin
         if (push) begin
            sum_in   = '0;
            taken_in = '0;
         end else begin
            sum_in   = sum_new;
            taken_in = taken_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         taken_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         taken_ff <= taken_in;
      end
   end

endmodule

// ===== rtl/core/tadc_fifo.sv =====
// Two-entry queue of finished averages between the front and back ends.
// Depends on tadc_pkg.
module tadc_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tadc_pkg::avg_type   push_data,
   output logic                full,
   input  logic                pop,
   output tadc_pkg::avg_type   pop_data,
   output logic                empty
);
   import tadc_pkg::*;

   avg_type                 entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]     count_ff, count_in;
   logic                    do_push, do_pop;

   assign full     = (count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (FIFO_PTR_W+1)'(do_push) - (FIFO_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/tadc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle over the whole 64-bit dividend.
// Depends on tadc_pkg.
module tadc_div (
   input  logic                    clock,
   input  logic                    reset,
   input  tadc_pkg::div_req_type   req,
   output tadc_pkg::div_rsp_type   rsp
);
   import tadc_pkg::*;

   logic                    busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0]    quo_ff, quo_in;
   logic [DIV_DEN_W:0]      rem_ff, rem_in;
   logic [DIV_DEN_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_DEN_W:0]      rem_sh;
   logic                    ge;

   assign rem_sh = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
   assign ge     = (rem_sh >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.quotient = quo_ff;

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== rtl/core/tadc_log2.sv =====
// Iterative log2 in Q24: normalize one bit per cycle, then 24 squarings.
// Depends on tadc_pkg.
module tadc_log2 (
   input  logic                    clock,
   input  logic                    reset,
   input  tadc_pkg::log_req_type   req,
   output tadc_pkg::log_rsp_type   rsp
);
   import tadc_pkg::*;

   localparam int M_W = 31;

   logic              busy_ff, busy_in;
   logic              squaring_ff, squaring_in;
   logic [M_W-1:0]    m_ff, m_in;
   logic [4:0]        k_ff, k_in;
   logic [23:0]       frac_ff, frac_in;
   logic [4:0]        iter_ff, iter_in;
   logic [2*M_W-1:0]  sq;
   logic [31:0]       sq_hi;

   assign sq    = m_ff * m_ff;
   assign sq_hi = sq[2*M_W-1:30];

   always_comb begin
      busy_in     = busy_ff;
      squaring_in = squaring_ff;
      m_in        = m_ff;
      k_in        = k_ff;
      frac_in     = frac_ff;
      iter_in     = iter_ff;
      if (busy_ff) begin
         if (!squaring_ff) begin
            if (m_ff[M_W-1] || k_ff == '0) begin
               squaring_in = 1'b1;
               iter_in     = '0;
            end else begin
               m_in = {m_ff[M_W-2:0], 1'b0};
               k_in = k_ff - 5'd1;
            end
         end else begin
            // mantissa stays in [1,2) as Q30; an overflow past 2 yields a one bit
            if (sq_hi[31]) begin
               m_in    = sq_hi[31:1];
               frac_in = {frac_ff[22:0], 1'b1};
            end else begin
               m_in    = sq_hi[30:0];
               frac_in = {frac_ff[22:0], 1'b0};
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd23) begin
               busy_in = 1'b0;
            end
         end
      end else if (req.start) begin
         busy_in     = 1'b1;
         squaring_in = 1'b0;
         m_in        = {{(M_W-LOG_IN_W){1'b0}}, req.x};
         k_in        = 5'd30;
         frac_in     = '0;
      end
   end

   assign rsp.busy  = busy_ff;
   assign rsp.value = {k_ff, frac_ff};

   always_ff @(posedge clock) begin
      squaring_ff <= squaring_in;
      m_ff        <= m_in;
      k_ff        <= k_in;
      frac_ff     <= frac_in;
      iter_ff     <= iter_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== rtl/core/tadc_back.sv =====
// Back end: sequencer that turns one average into voltage, resistance and
// temperatures using the shared divider and log units. Depends on tadc_pkg, tadc_if.
module tadc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  tadc_pkg::cfg_type       cfg,
   input  logic                    fifo_empty,
   input  tadc_pkg::avg_type       fifo_data,
   output logic                    fifo_pop,
   output tadc_pkg::div_req_type   div_req,
   input  tadc_pkg::div_rsp_type   div_rsp,
   output tadc_pkg::log_req_type   log_req,
   input  tadc_pkg::log_rsp_type   log_rsp,
   tadc_rsp_if.source              rsp_chan
);
   import tadc_pkg::*;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_VO_MUL    = 4'd1;
   localparam logic [3:0] ST_VO_DIV    = 4'd2;
   localparam logic [3:0] ST_RT_MUL    = 4'd3;
   localparam logic [3:0] ST_RT_START  = 4'd4;
   localparam logic [3:0] ST_RT_DIV    = 4'd5;
   localparam logic [3:0] ST_LOG_REST  = 4'd6;
   localparam logic [3:0] ST_LN_MUL    = 4'd7;
   localparam logic [3:0] ST_D_MUL     = 4'd8;
   localparam logic [3:0] ST_D_SUM     = 4'd9;
   localparam logic [3:0] ST_NUM       = 4'd10;
   localparam logic [3:0] ST_CEL_START = 4'd11;
   localparam logic [3:0] ST_CEL_DIV   = 4'd12;
   localparam logic [3:0] ST_FAH_START = 4'd13;
   localparam logic [3:0] ST_FAH_DIV   = 4'd14;
   localparam logic [3:0] ST_DONE      = 4'd15;

   function automatic logic signed [TEMP_W-1:0] sat_q16(input logic [DIV_NUM_W-1:0] q,
                                                        input logic neg);
      logic signed [TEMP_W-1:0] r;
      if (neg) begin
         r = (q > 64'd32768) ? -16'sd32768 : -$signed(q[TEMP_W-1:0]);
      end else begin
         r = (q > 64'd32767) ? 16'sd32767 : $signed(q[TEMP_W-1:0]);
      end
      return r;
   endfunction

   logic [3:0]                state_ff, state_in;
   logic                      neg_ff, neg_in;
   logic [45:0]               prod_ff, prod_in;
   logic [21:0]               divisor_ff, divisor_in;
   logic signed [VO_W-1:0]    vo_ff, vo_in;
   logic [21:0]               rest_ff, rest_in;
   logic [OHMS_W-1:0]         rt_ff, rt_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic [LOG_W-1:0]          l1_ff, l1_in;
   logic signed [LOG_W:0]     dl_ff, dl_in;
   logic [60:0]               lnp_ff, lnp_in;
   logic signed [39:0]        t0lq_ff, t0lq_in;
   logic [31:0]               tb_ff, tb_in;
   logic signed [40:0]        d_ff, d_in;
   logic [54:0]               n_ff, n_in;
   logic signed [61:0]        numc_ff, numc_in, numf_ff, numf_in;
   logic signed [TEMP_W-1:0]  cel_ff, cel_in, fah_ff, fah_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0]  out_cel_ff, out_fah_ff;
   logic signed [VO_W-1:0]    out_vo_ff;
   logic [OHMS_W-1:0]         out_rt_ff;
   logic [STATUS_W-1:0]       out_status_ff;

   logic signed [SUM_W-1:0]   sum_abs_s;
   logic [21:0]               sum_mag;
   logic [22:0]               q_vo;
   logic signed [VO_W-1:0]    vo_cand;
   logic [LOG_W-1:0]          dl_mag;
   logic [61:0]               ln_round;
   logic [21:0]               lnm;
   logic signed [22:0]        lq;
   logic [20:0]               beta25;
   logic [36:0]               tb25;
   logic signed [61:0]        n62, d62;
   logic [40:0]               d_mag;
   logic [44:0]               d5;
   logic [61:0]               numc_mag, numf_mag;
   logic                      out_free, load_out;

   assign sum_abs_s = fifo_data.sum[SUM_W-1] ? -fifo_data.sum : fifo_data.sum;
   assign sum_mag   = sum_abs_s[21:0];
   assign q_vo      = (div_rsp.quotient > 64'(FULL_SCALE_UV)) ? FULL_SCALE_UV
                                                              : div_rsp.quotient[22:0];
   assign vo_cand   = neg_ff ? -$signed(q_vo) : $signed(q_vo);

   assign dl_mag    = dl_ff[LOG_W] ? LOG_W'(-dl_ff) : dl_ff[LOG_W-1:0];
   assign ln_round  = 62'(lnp_ff) + (62'd1 << 39);
   assign lnm       = ln_round[61:40];
   assign lq        = neg_ff ? -$signed({1'b0, lnm}) : $signed({1'b0, lnm});

   assign beta25    = 21'(cfg.beta_kelvin) * 21'd25;
   assign tb25      = 37'(tb_ff) * 37'd25;
   assign n62       = $signed({7'b0, n_ff});
   assign d62       = $signed({{21{d_ff[40]}}, d_ff});

   assign d_mag     = d_ff[40] ? 41'(-d_ff) : 41'(d_ff);
   assign d5        = 45'(d_mag) * 45'd5;
   assign numc_mag  = numc_ff[61] ? 62'(-numc_ff) : 62'(numc_ff);
   assign numf_mag  = numf_ff[61] ? 62'(-numf_ff) : 62'(numf_ff);

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign load_out  = (state_ff == ST_DONE) && out_free;
   assign fifo_pop  = (state_ff == ST_IDLE) && !fifo_empty;

   always_comb begin
      state_in   = state_ff;
      neg_in     = neg_ff;
      prod_in    = prod_ff;
      divisor_in = divisor_ff;
      vo_in      = vo_ff;
      rest_in    = rest_ff;
      rt_in      = rt_ff;
      status_in  = status_ff;
      l1_in      = l1_ff;
      dl_in      = dl_ff;
      lnp_in     = lnp_ff;
      t0lq_in    = t0lq_ff;
      tb_in      = tb_ff;
      d_in       = d_ff;
      n_in       = n_ff;
      numc_in    = numc_ff;
      numf_in    = numf_ff;
      cel_in     = cel_ff;
      fah_in     = fah_ff;
      div_req.start    = 1'b0;
      div_req.dividend = 64'(prod_ff) + 64'(divisor_ff >> 1);
      div_req.divisor  = 45'(divisor_ff);
      log_req.start    = 1'b0;
      log_req.x        = {1'b0, vo_ff[21:0]};

      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               prod_in    = 46'(sum_mag) * 46'(FULL_SCALE_UV);
               divisor_in = 22'(fifo_data.cnt) * 22'(CODE_FULL);
               neg_in     = fifo_data.sum[SUM_W-1];
               state_in   = ST_VO_MUL;
            end
         end
         ST_VO_MUL: begin
            div_req.start = 1'b1;
            state_in      = ST_VO_DIV;
         end
         ST_VO_DIV: begin
            if (!div_rsp.busy) begin
               vo_in  = vo_cand;
               rt_in  = '0;
               cel_in = '0;
               fah_in = '0;
               priority if (vo_cand[VO_W-1] || vo_cand == '0) begin
                  status_in = STATUS_LOW;
                  state_in  = ST_DONE;
               end else if (vo_cand[21:0] >= cfg.supply_microvolts) begin
                  status_in = STATUS_HIGH;
                  state_in  = ST_DONE;
               end else begin
                  status_in = STATUS_OK;
                  rest_in   = cfg.supply_microvolts - vo_cand[21:0];
                  state_in  = ST_RT_MUL;
               end
            end
         end
         ST_RT_MUL: begin
            prod_in  = 46'(cfg.balance_ohms) * 46'(vo_ff[21:0]);
            state_in = ST_RT_START;
         end
         ST_RT_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'(prod_ff) + 64'(rest_ff >> 1);
            div_req.divisor  = 45'(rest_ff);
            log_req.start    = 1'b1;
            state_in         = ST_RT_DIV;
         end
         ST_RT_DIV: begin
            if (!div_rsp.busy && !log_rsp.busy) begin
               rt_in         = (div_rsp.quotient > 64'(24'hFFFFFF)) ? 24'hFFFFFF
                                                                    : div_rsp.quotient[23:0];
               l1_in         = log_rsp.value;
               log_req.start = 1'b1;
               log_req.x     = {1'b0, rest_ff};
               state_in      = ST_LOG_REST;
            end
         end
         ST_LOG_REST: begin
            if (!log_rsp.busy) begin
               dl_in    = $signed({1'b0, l1_ff}) - $signed({1'b0, log_rsp.value});
               state_in = ST_LN_MUL;
            end
         end
         ST_LN_MUL: begin
            lnp_in   = 61'(dl_mag) * 61'(LN2_Q32);
            neg_in   = dl_ff[LOG_W];
            state_in = ST_D_MUL;
         end
         ST_D_MUL: begin
            t0lq_in  = $signed({1'b0, cfg.nominal_centikelvin}) * lq;
            tb_in    = 32'(cfg.nominal_centikelvin) * 32'(cfg.beta_kelvin);
            state_in = ST_D_SUM;
         end
         ST_D_SUM: begin
            // B*6553600 = (B*25) << 18
            d_in     = 41'(t0lq_ff) + $signed({2'b0, beta25, 18'b0});
            n_in     = {tb25, 18'b0};
            state_in = ST_NUM;
         end
         ST_NUM: begin
            numc_in = n62 - d62 * 62'sd27315;
            numf_in = n62 * 62'sd9 - d62 * 62'sd229835;
            if (d_ff == '0) begin
               cel_in   = 16'sd32767;
               fah_in   = 16'sd32767;
               state_in = ST_DONE;
            end else begin
               state_in = ST_CEL_START;
            end
         end
         ST_CEL_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'(numc_mag) + 64'(d_mag >> 1);
            div_req.divisor  = 45'(d_mag);
            state_in         = ST_CEL_DIV;
         end
         ST_CEL_DIV: begin
            if (!div_rsp.busy) begin
               cel_in   = sat_q16(div_rsp.quotient, numc_ff[61] ^ d_ff[40]);
               state_in = ST_FAH_START;
            end
         end
         ST_FAH_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'(numf_mag) + 64'(d5 >> 1);
            div_req.divisor  = d5;
            state_in         = ST_FAH_DIV;
         end
         ST_FAH_DIV: begin
            if (!div_rsp.busy) begin
               fah_in   = sat_q16(div_rsp.quotient, numf_ff[61] ^ d_ff[40]);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.celsius_centi      = out_cel_ff;
   assign rsp_chan.fahrenheit_centi   = out_fah_ff;
   assign rsp_chan.divider_microvolts = out_vo_ff;
   assign rsp_chan.thermistor_ohms    = out_rt_ff;
   assign rsp_chan.status             = out_status_ff;

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      prod_ff    <= prod_in;
      divisor_ff <= divisor_in;
      vo_ff      <= vo_in;
      rest_ff    <= rest_in;
      rt_ff      <= rt_in;
      status_ff  <= status_in;
      l1_ff      <= l1_in;
      dl_ff      <= dl_in;
      lnp_ff     <= lnp_in;
      t0lq_ff    <= t0lq_in;
      tb_ff      <= tb_in;
      d_ff       <= d_in;
      n_ff       <= n_in;
      numc_ff    <= numc_in;
      numf_ff    <= numf_in;
      cel_ff     <= cel_in;
      fah_ff     <= fah_in;
      if (load_out) begin
         out_cel_ff    <= cel_ff;
         out_fah_ff    <= fah_ff;
         out_vo_ff     <= vo_ff;
         out_rt_ff     <= rt_ff;
         out_status_ff <= status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/thermistor_adc_to_temperature.sv =====
// NTC thermistor temperature from averaged ADC codes, Beta equation.
// Top level; depends on tadc_pkg, tadc_if, tadc_front, tadc_fifo, tadc_div,
// tadc_log2 and tadc_back.
//
// req_chan carries signed 16-bit ADC codes (valid/ready). Every sample_count
// codes (zero taken as one, at most 64) close one average, which produces one
// transaction on rsp_chan: Celsius and Fahrenheit in hundredths, divider
// voltage in microvolts, thermistor ohms and a status code. Registers are
// written through csr_wr_en/csr_index/csr_wdata; the user must write them only
// while the block is idle, which the block itself does not enforce.
// Codes are taken one per cycle while the two-entry average queue has room.
// For each average the back end makes up to four passes of the shared radix-2
// divider and up to two log2 passes, the first overlapping the resistance divide.
// A finished result waits in an output register; while the receiver stalls,
// the back end finishes its next average and the front end keeps filling the
// queue, then req_chan.ready drops. Synchronous reset clears the running sum,
// the queue and the sequencer and restores the register defaults.
module thermistor_adc_to_temperature (
   input  logic                              clock,
   input  logic                              reset,
   tadc_req_if.sink                          req_chan,
   tadc_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [tadc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tadc_pkg::CSR_DAT_W-1:0]    csr_wdata
);
   import tadc_pkg::*;

   logic [CNT_W-1:0]  sample_count_ff;
   cfg_type           cfg_ff;

   logic              push, fifo_full, fifo_empty, fifo_pop;
   avg_type           push_data, pop_data;
   div_req_type       div_req;
   div_rsp_type       div_rsp;
   log_req_type       log_req;
   log_rsp_type       log_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff            <= 7'd5;
         cfg_ff.balance_ohms        <= 24'd100000;
         cfg_ff.beta_kelvin         <= 16'd3950;
         cfg_ff.nominal_centikelvin <= 16'd29815;
         cfg_ff.supply_microvolts   <= 22'd3285000;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_ff            <= csr_wdata[6:0];
            CSR_BALANCE_OHMS: cfg_ff.balance_ohms        <= csr_wdata[23:0];
            CSR_BETA_KELVIN:  cfg_ff.beta_kelvin         <= csr_wdata[15:0];
            CSR_NOMINAL_CK:   cfg_ff.nominal_centikelvin <= csr_wdata[15:0];
            CSR_SUPPLY_UV:    cfg_ff.supply_microvolts   <= csr_wdata[21:0];
            default: begin
            end
         endcase
      end
   end

   tadc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .sample_count (sample_count_ff),
      .req_chan     (req_chan),
      .fifo_full    (fifo_full),
      .push         (push),
      .push_data    (push_data)
   );

   tadc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (pop_data),
      .empty     (fifo_empty)
   );

   tadc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tadc_log2 u_log2 (
      .clock (clock),
      .reset (reset),
      .req   (log_req),
      .rsp   (log_rsp)
   );

   tadc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fifo_empty (fifo_empty),
      .fifo_data  (pop_data),
      .fifo_pop   (fifo_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .log_req    (log_req),
      .log_rsp    (log_rsp),
      .rsp_chan   (rsp_chan)
   );

endmodule
